>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, operation and status codes, and the token that travels
// along the row of bitmap cells.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int OFFSET_W    = 24;   // byte offset width
    localparam int IDX_W       = 9;    // block index width (any count the register can hold)
    localparam int LOG2_W      = 5;    // block_size_log2 register width
    localparam int COUNT_W     = 9;    // blocks_in_use register width
    localparam int CFG_DATA_W  = 9;    // widest configuration register
    localparam int CFG_INDEX_W = 1;    // two configuration registers

    localparam logic [LOG2_W-1:0]  MAX_LOG2    = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic {
        CFG_BLOCK_SIZE_LOG2 = 1'b0,
        CFG_BLOCKS_IN_USE   = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADOFF  = 2'd2,
        ST_NOTUSED = 2'd3
    } t_status;

    // A request on its way through the cells. Once done is set, the
    // remaining cells pass it on untouched.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             done;
        t_status          status;
        logic [IDX_W-1:0] index;
    } t_token;

endpackage

>>> rtl/bba_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request per transaction.
// ----------------------------------------------------------------------------
interface bba_in_if;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [bba_pkg::OFFSET_W-1:0]  free_offset;

    modport source (output valid, output operation, output free_offset, input ready);
    modport sink   (input valid, input operation, input free_offset, output ready);

endinterface

>>> rtl/bba_out_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status and offset per transaction.
// ----------------------------------------------------------------------------
interface bba_out_if;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_status;
    logic [bba_pkg::OFFSET_W-1:0]  alloc_offset;

    modport source (output valid, output result_status, output alloc_offset, input ready);
    modport sink   (input valid, input result_status, input alloc_offset, output ready);

endinterface

>>> rtl/bba_cell.sv
// ----------------------------------------------------------------------------
// Bitmap cell
// Holds one word of the used bitmap and serves a passing token: claims its
// lowest free block for an allocate, or clears the addressed bit for a free.
// ----------------------------------------------------------------------------
module bba_cell #(
    parameter int WORD_BITS = 32,
    parameter int BASE      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bba_pkg::COUNT_W-1:0]  i_count,
    input  bba_pkg::t_token              i_tok,
    output bba_pkg::t_token              o_tok
);

    localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    bba_pkg::t_token      r_tok;
    bba_pkg::t_token      n_tok;

    logic [WORD_BITS-1:0] w_avail;
    logic [BW-1:0]        w_pos;
    logic [BW-1:0]        w_loc;
    logic                 w_hit;

    // Blocks that are free and inside the configured pool.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_avail[j] = ~r_word[j] & ((BASE + j) < int'(i_count));
        end
    end

    // Lowest available bit.
    always_comb begin
        w_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                w_pos = BW'(j);
            end
        end
    end

    always_comb begin
        int loc_i;
        loc_i = int'(i_tok.index) - BASE;
        w_hit = (int'(i_tok.index) >= BASE) && (int'(i_tok.index) < BASE + WORD_BITS);
        w_loc = loc_i[BW-1:0];
    end

    always_comb begin
        n_word = r_word;
        n_tok  = i_tok;
        if (i_tok.valid && !i_tok.done) begin
            if (i_tok.op == bba_pkg::OP_ALLOC) begin
                if (|w_avail) begin
                    n_word[w_pos] = 1'b1;
                    n_tok.done    = 1'b1;
                    n_tok.status  = bba_pkg::ST_OK;
                    n_tok.index   = bba_pkg::IDX_W'(BASE + int'(w_pos));
                end
            end else if (w_hit) begin
                n_tok.done = 1'b1;
                if (r_word[w_loc]) begin
                    n_word[w_loc] = 1'b0;
                    n_tok.status  = bba_pkg::ST_OK;
                end else begin
                    n_tok.status  = bba_pkg::ST_NOTUSED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_tok  <= '0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a pool of power-of-two sized blocks with one used
// bit per block, held in a row of bitmap cells.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transaction content
// --------  ---  -----------------------------------------------------------
// i_req     in   operation (0 allocate, 1 free), free_offset (24 bits)
// o_rsp     out  result_status (2 bits), alloc_offset (24 bits)
// i_cfg_*   in   write enable, register index, write data (no handshake)
//
// From acceptance to a valid response, each request passes through the
// request register loaded at the accepting edge, the token register of each
// bitmap cell in turn, and the response register. Ready returns as the
// response is loaded, so no new request is taken while a token is in the row.
// One request is in flight at a time; the next one is accepted as soon as
// the previous token leaves the row, even while its response still waits.
// Reset is synchronous and clears the whole bitmap to free at once; a
// response that meets a stalled output register is parked in a holding
// register, and requests are refused while that register is occupied.
//
module bitmap_block_allocator #(
    parameter int TOTAL_BLOCKS  = 256,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bba_in_if.sink                            i_req,
    bba_out_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int MAP_WORDS = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int OW        = bba_pkg::OFFSET_W;

    // ------------------------------------------------------------------
    // Configuration registers and their effective values
    // ------------------------------------------------------------------
    logic [bba_pkg::LOG2_W-1:0]  r_log2;
    logic [bba_pkg::COUNT_W-1:0] r_count;
    logic [bba_pkg::LOG2_W-1:0]  w_sh;
    logic [bba_pkg::COUNT_W-1:0] w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2  <= '0;
            r_count <= bba_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (bba_pkg::t_cfg_reg'(i_cfg_index))
                bba_pkg::CFG_BLOCK_SIZE_LOG2: r_log2  <= i_cfg_data[bba_pkg::LOG2_W-1:0];
                bba_pkg::CFG_BLOCKS_IN_USE:   r_count <= i_cfg_data[bba_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Oversized settings saturate: block size at 64 KiB, count at the pool.
    assign w_sh    = (r_log2 > bba_pkg::MAX_LOG2) ? bba_pkg::MAX_LOG2 : r_log2;
    assign w_count = (int'(r_count) > TOTAL_BLOCKS) ? bba_pkg::COUNT_W'(TOTAL_BLOCKS) : r_count;

    // ------------------------------------------------------------------
    // Request check and token injection
    // ------------------------------------------------------------------
    logic            r_busy;
    logic            n_busy;
    logic            w_in_acc;
    logic [OW-1:0]   w_low_mask;
    logic [OW-1:0]   w_idx;
    logic            w_bad;
    bba_pkg::t_token r_tok_in;
    bba_pkg::t_token n_tok_in;

    // The hold register is declared here as it gates acceptance.
    logic r_hold_valid;

    assign i_req.ready = ~r_busy & ~r_hold_valid;
    assign w_in_acc    = i_req.valid & i_req.ready;

    // A free must be block aligned and name a block inside the pool.
    assign w_low_mask = (OW'(1) << w_sh) - OW'(1);
    assign w_idx      = i_req.free_offset >> w_sh;
    assign w_bad      = (|(i_req.free_offset & w_low_mask))
                        || (w_idx >= OW'(w_count));

    always_comb begin
        n_tok_in.valid  = w_in_acc;
        n_tok_in.op     = bba_pkg::t_op'(i_req.operation);
        n_tok_in.done   = (n_tok_in.op == bba_pkg::OP_FREE) && w_bad;
        n_tok_in.status = w_bad ? bba_pkg::ST_BADOFF : bba_pkg::ST_OK;
        n_tok_in.index  = w_idx[bba_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_in <= '0;
        end else begin
            r_tok_in <= n_tok_in;
        end
    end

    // ------------------------------------------------------------------
    // Row of bitmap cells; the token moves one cell per cycle
    // ------------------------------------------------------------------
    bba_pkg::t_token       w_tok [MAP_WORDS+1];
    logic [MAP_WORDS:0]    w_tok_valid;

    assign w_tok[0] = r_tok_in;

    for (genvar g = 0; g < MAP_WORDS; g++) begin : g_cell
        bba_cell #(
            .WORD_BITS (MAP_WORD_BITS),
            .BASE      (g * MAP_WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (w_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    for (genvar g = 0; g <= MAP_WORDS; g++) begin : g_valid
        assign w_tok_valid[g] = w_tok[g].valid;
    end

    // ------------------------------------------------------------------
    // Response formation
    // ------------------------------------------------------------------
    bba_pkg::t_token  w_exit;
    bba_pkg::t_status w_status;
    logic [OW-1:0]    w_offset;

    assign w_exit = w_tok[MAP_WORDS];

    // An allocate that found no free block in any cell means the pool is full.
    assign w_status = (!w_exit.done) ? bba_pkg::ST_FULL : w_exit.status;
    assign w_offset = ((w_exit.op == bba_pkg::OP_ALLOC) && (w_status == bba_pkg::ST_OK))
                      ? (OW'(w_exit.index) << w_sh) : '0;

    always_comb begin
        n_busy = r_busy;
        if (w_in_acc) begin
            n_busy = 1'b1;
        end else if (w_exit.valid) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a holding register behind it
    // ------------------------------------------------------------------
    logic                   r_out_valid;
    logic                   n_out_valid;
    bba_pkg::t_status       r_out_status;
    bba_pkg::t_status       n_out_status;
    logic [OW-1:0]          r_out_offset;
    logic [OW-1:0]          n_out_offset;
    logic                   n_hold_valid;
    bba_pkg::t_status       r_hold_status;
    bba_pkg::t_status       n_hold_status;
    logic [OW-1:0]          r_hold_offset;
    logic [OW-1:0]          n_hold_offset;
    logic                   w_out_free;

    assign w_out_free = ~r_out_valid | o_rsp.ready;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_offset  = r_out_offset;
        n_hold_valid  = r_hold_valid;
        n_hold_status = r_hold_status;
        n_hold_offset = r_hold_offset;
        if (w_exit.valid) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = w_status;
                n_out_offset = w_offset;
            end else begin
                n_hold_valid  = 1'b1;
                n_hold_status = w_status;
                n_hold_offset = w_offset;
            end
        end else if (r_hold_valid && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = r_hold_status;
            n_out_offset = r_hold_offset;
            n_hold_valid = 1'b0;
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
        r_out_status  <= n_out_status;
        r_out_offset  <= n_out_offset;
        r_hold_status <= n_hold_status;
        r_hold_offset <= n_hold_offset;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_status = r_out_status;
    assign o_rsp.alloc_offset  = r_out_offset;

`ifndef NO_ASSERTIONS
    // Only one request may be in the row at any time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one token in the cell row");

    // A token leaving the row must belong to an accepted request.
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_busy)
        else $error("token left the row while idle");

    // Once the token has left, the busy flag is clear; only an occupied holding register can still refuse a request.
    a_exit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |=> !r_busy)
        else $error("still busy after the token left the row");

    // The holding register is only used behind a stalled output register.
    a_hold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("holding register occupied with the output empty");
`endif

endmodule
